/* rtl/rpt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types, codes and helpers of the route pattern tokenizer.
// ----------------------------------------------------------------------------
package rpt_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CNT_W           = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [3:0] K_MATCH     = 4'd0;
    localparam logic [3:0] K_CAP_UNTIL = 4'd1;
    localparam logic [3:0] K_FIND_FWD  = 4'd2;
    localparam logic [3:0] K_FIND_REV  = 4'd3;
    localparam logic [3:0] K_CAP_END   = 4'd4;
    localparam logic [3:0] K_CAP_BYTES = 4'd5;
    localparam logic [3:0] K_JUMP_FWD  = 4'd6;
    localparam logic [3:0] K_JUMP_BACK = 4'd7;
    localparam logic [3:0] K_JUMP_END  = 4'd8;
    localparam logic [3:0] K_JUMP_ABS  = 4'd9;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_NO_DOLLAR = 3'd1;
    localparam logic [2:0] ERR_UNEXPECT  = 3'd2;
    localparam logic [2:0] ERR_ESCAPE    = 3'd3;
    localparam logic [2:0] ERR_HEX       = 3'd4;
    localparam logic [2:0] ERR_ZERO_CAP  = 3'd5;
    localparam logic [2:0] ERR_MID_TOKEN = 3'd6;

    typedef struct packed {
        logic [3:0]       kind;
        logic             text_valid;
        logic [7:0]       text_byte;
        logic             done;
        logic [CNT_W-1:0] count;
        logic [2:0]       err;
        logic             last;
    } rpt_entry_t;

    typedef struct packed {
        logic ok;
        logic [3:0] nibble;
    } rpt_hex_t;

    function automatic rpt_hex_t hex_of(input logic [7:0] c);
        rpt_hex_t r;
        r.ok     = 1'b1;
        r.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r.nibble = c[3:0];
        else if (c >= 8'h61 && c <= 8'h66)
            r.nibble = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            r.nibble = 4'(c - 8'h37);
        else
            r.ok = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/rpt_lexer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_lexer
// Front end: accepts pattern bytes, runs the lexer state machine and builds
// one queue entry for each byte that yields a result.
// ----------------------------------------------------------------------------
module rpt_lexer #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      fire,
    input  wire  [7:0]               pattern_byte,
    input  wire                      is_last,
    output logic                     push,
    output rpt_pkg::rpt_entry_t      entry
);
    import rpt_pkg::*;

    localparam int SAT_W = (COUNT_WIDTH < CNT_W) ? COUNT_WIDTH : CNT_W;
    localparam logic [SAT_W-1:0] SAT_MAX = {SAT_W{1'b1}};

    localparam logic [4:0] ST_IDLE       = 5'd0;
    localparam logic [4:0] ST_DOLLAR     = 5'd1;
    localparam logic [4:0] ST_BRACE      = 5'd2;
    localparam logic [4:0] ST_BRACE_NUM  = 5'd3;
    localparam logic [4:0] ST_BRACKET    = 5'd4;
    localparam logic [4:0] ST_GT         = 5'd5;
    localparam logic [4:0] ST_LT         = 5'd6;
    localparam logic [4:0] ST_NUM_BRK    = 5'd7;
    localparam logic [4:0] ST_E1         = 5'd8;
    localparam logic [4:0] ST_E2         = 5'd9;
    localparam logic [4:0] ST_E3         = 5'd10;
    localparam logic [4:0] ST_END_MINUS  = 5'd11;
    localparam logic [4:0] ST_QUOTE      = 5'd12;
    localparam logic [4:0] ST_ESC        = 5'd13;
    localparam logic [4:0] ST_HEX1       = 5'd14;
    localparam logic [4:0] ST_HEX2       = 5'd15;
    localparam logic [4:0] ST_AFTER_Q    = 5'd16;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_X   = 8'h78;

    logic [4:0]       state_reg, state_next;
    logic [3:0]       kind_reg, kind_next;
    logic [SAT_W-1:0] acc_reg, acc_next;
    logic [3:0]       hex_reg, hex_next;
    logic             latch_reg, latch_next;

    logic             have, tv, done, use_cnt;
    logic [7:0]       tb;
    logic [2:0]       err;
    logic [4:0]       st;
    logic [3:0]       kd;
    logic             is_dig;
    logic [SAT_W-1:0] acc_dig;
    logic [SAT_W-1:0] acc_first;
    logic [SAT_W+3:0] acc_wide;
    rpt_hex_t         hx;

    assign is_dig   = (pattern_byte >= CH_ZERO) && (pattern_byte <= CH_NINE);
    assign acc_wide = {4'd0, acc_reg} * (SAT_W + 4)'(10) + (SAT_W + 4)'(pattern_byte[3:0]);
    assign acc_dig  = (acc_wide > {4'd0, SAT_MAX}) ? SAT_MAX : acc_wide[SAT_W-1:0];
    assign acc_first = SAT_W'(pattern_byte[3:0]);
    assign hx       = hex_of(pattern_byte);

    always_comb
    begin
        st      = state_reg;
        kd      = kind_reg;
        acc_next = acc_reg;
        hex_next = hex_reg;
        have    = 1'b0;
        tv      = 1'b0;
        done    = 1'b0;
        use_cnt = 1'b0;
        tb      = 8'd0;
        err     = ERR_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pattern_byte == CH_DOLLAR) st = ST_DOLLAR;
                else err = ERR_NO_DOLLAR;
            end
            ST_DOLLAR:
            begin
                if (pattern_byte == CH_QUOTE)
                begin
                    kd = K_MATCH;
                    st = ST_QUOTE;
                end
                else if (pattern_byte == CH_LBRACE) st = ST_BRACE;
                else if (pattern_byte == CH_LBRACK) st = ST_BRACKET;
                else err = ERR_UNEXPECT;
            end
            ST_BRACE:
            begin
                if (pattern_byte == CH_RBRACE)
                begin
                    have = 1'b1;
                    done = 1'b1;
                    kd   = K_CAP_END;
                    st   = ST_IDLE;
                end
                else if (pattern_byte == CH_QUOTE)
                begin
                    kd = K_CAP_UNTIL;
                    st = ST_QUOTE;
                end
                else if (is_dig)
                begin
                    kd       = K_CAP_BYTES;
                    acc_next = acc_first;
                    st       = ST_BRACE_NUM;
                end
                else err = ERR_UNEXPECT;
            end
            ST_BRACE_NUM:
            begin
                if (is_dig) acc_next = acc_dig;
                else if (acc_reg == '0) err = ERR_ZERO_CAP;
                else if (pattern_byte == CH_RBRACE)
                begin
                    have    = 1'b1;
                    done    = 1'b1;
                    use_cnt = 1'b1;
                    st      = ST_IDLE;
                end
                else err = ERR_UNEXPECT;
            end
            ST_BRACKET:
            begin
                if (pattern_byte == CH_GT) st = ST_GT;
                else if (pattern_byte == CH_LT) st = ST_LT;
                else if (pattern_byte == CH_E) st = ST_E1;
                else if (is_dig)
                begin
                    kd       = K_JUMP_ABS;
                    acc_next = acc_first;
                    st       = ST_NUM_BRK;
                end
                else err = ERR_UNEXPECT;
            end
            ST_GT, ST_LT:
            begin
                if (pattern_byte == CH_QUOTE)
                begin
                    kd = (state_reg == ST_GT) ? K_FIND_FWD : K_FIND_REV;
                    st = ST_QUOTE;
                end
                else if (is_dig)
                begin
                    kd       = (state_reg == ST_GT) ? K_JUMP_FWD : K_JUMP_BACK;
                    acc_next = acc_first;
                    st       = ST_NUM_BRK;
                end
                else err = ERR_UNEXPECT;
            end
            ST_NUM_BRK:
            begin
                if (is_dig) acc_next = acc_dig;
                else if (pattern_byte == CH_RBRACK)
                begin
                    have    = 1'b1;
                    done    = 1'b1;
                    use_cnt = 1'b1;
                    st      = ST_IDLE;
                end
                else err = ERR_UNEXPECT;
            end
            ST_E1:
            begin
                if (pattern_byte == CH_N) st = ST_E2;
                else err = ERR_UNEXPECT;
            end
            ST_E2:
            begin
                if (pattern_byte == CH_D) st = ST_E3;
                else err = ERR_UNEXPECT;
            end
            ST_E3:
            begin
                kd = K_JUMP_END;
                if (pattern_byte == CH_RBRACK)
                begin
                    have = 1'b1;
                    done = 1'b1;
                    st   = ST_IDLE;
                end
                else if (pattern_byte == CH_MINUS) st = ST_END_MINUS;
                else err = ERR_UNEXPECT;
            end
            ST_END_MINUS:
            begin
                if (is_dig)
                begin
                    kd       = K_JUMP_END;
                    acc_next = acc_first;
                    st       = ST_NUM_BRK;
                end
                else err = ERR_UNEXPECT;
            end
            ST_QUOTE:
            begin
                if (pattern_byte == CH_QUOTE)
                begin
                    if (kind_reg == K_MATCH)
                    begin
                        have = 1'b1;
                        done = 1'b1;
                        st   = ST_IDLE;
                    end
                    else st = ST_AFTER_Q;
                end
                else if (pattern_byte == CH_BSLASH) st = ST_ESC;
                else
                begin
                    have = 1'b1;
                    tv   = 1'b1;
                    tb   = pattern_byte;
                end
            end
            ST_ESC:
            begin
                st = ST_QUOTE;
                priority if (pattern_byte == CH_BSLASH || pattern_byte == CH_QUOTE)
                begin
                    have = 1'b1;
                    tv   = 1'b1;
                    tb   = pattern_byte;
                end
                else if (pattern_byte == CH_LC_N)
                begin
                    have = 1'b1;
                    tv   = 1'b1;
                    tb   = 8'd10;
                end
                else if (pattern_byte == CH_LC_T)
                begin
                    have = 1'b1;
                    tv   = 1'b1;
                    tb   = 8'd9;
                end
                else if (pattern_byte == CH_LC_R)
                begin
                    have = 1'b1;
                    tv   = 1'b1;
                    tb   = 8'd13;
                end
                else if (pattern_byte == CH_ZERO)
                begin
                    have = 1'b1;
                    tv   = 1'b1;
                    tb   = 8'd0;
                end
                else if (pattern_byte == CH_LC_X) st = ST_HEX1;
                else err = ERR_ESCAPE;
            end
            ST_HEX1:
            begin
                if (!hx.ok) err = ERR_HEX;
                else
                begin
                    hex_next = hx.nibble;
                    st       = ST_HEX2;
                end
            end
            ST_HEX2:
            begin
                if (!hx.ok) err = ERR_HEX;
                else
                begin
                    have = 1'b1;
                    tv   = 1'b1;
                    tb   = {hex_reg, hx.nibble};
                    st   = ST_QUOTE;
                end
            end
            ST_AFTER_Q:
            begin
                if (pattern_byte == ((kind_reg == K_CAP_UNTIL) ? CH_RBRACE : CH_RBRACK))
                begin
                    have = 1'b1;
                    done = 1'b1;
                    st   = ST_IDLE;
                end
                else err = ERR_UNEXPECT;
            end
            default:
            begin
                err = ERR_UNEXPECT;
            end
        endcase

        if (err == ERR_OK && is_last && st != ST_IDLE) err = ERR_MID_TOKEN;

        state_next = st;
        kind_next  = kd;
        latch_next = latch_reg;
        if (latch_reg)
        begin
            if (is_last) latch_next = 1'b0;
        end
        else if (err != ERR_OK || done)
        begin
            state_next = ST_IDLE;
            kind_next  = K_MATCH;
            acc_next   = '0;
            hex_next   = 4'd0;
            latch_next = (err != ERR_OK) && !is_last;
        end
        if (latch_reg)
        begin
            state_next = ST_IDLE;
            kind_next  = K_MATCH;
            acc_next   = '0;
            hex_next   = 4'd0;
        end

        push             = fire && !latch_reg && (have || err != ERR_OK);
        entry.kind       = kd;
        entry.text_valid = tv;
        entry.text_byte  = tb;
        entry.done       = done;
        entry.count      = use_cnt ? CNT_W'(acc_reg) : '0;
        entry.err        = err;
        entry.last       = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= K_MATCH;
            acc_reg   <= '0;
            hex_reg   <= 4'd0;
            latch_reg <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            acc_reg   <= acc_next;
            hex_reg   <= hex_next;
            latch_reg <= latch_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/rpt_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_queue
// Short flop queue between the lexer and the output stage.
// ----------------------------------------------------------------------------
module rpt_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  rpt_pkg::rpt_entry_t  push_data,
    input  wire                  pop,
    output logic                 full,
    output logic                 not_empty,
    output rpt_pkg::rpt_entry_t  head
);
    import rpt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    rpt_entry_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop) rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

/* rtl/rpt_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_out
// Back end: pops queue entries, formats the result fields and holds them in
// the output register until the transaction completes.
// ----------------------------------------------------------------------------
module rpt_out (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  head_valid,
    input  rpt_pkg::rpt_entry_t  head,
    output logic                 pop,
    output logic                 tok_valid,
    input  wire                  tok_ready,
    output logic [3:0]           token_kind,
    output logic                 text_valid,
    output logic [7:0]           text_byte,
    output logic                 token_done,
    output logic [31:0]          count_value,
    output logic [2:0]           error_code,
    output logic                 pattern_end
);
    import rpt_pkg::*;

    logic             valid_reg;
    logic [3:0]       kind_reg;
    logic             tv_reg;
    logic [7:0]       tb_reg;
    logic             done_reg;
    logic [31:0]      cnt_reg;
    logic [2:0]       err_reg;
    logic             end_reg;
    logic             is_err;

    assign pop    = head_valid && (!valid_reg || tok_ready);
    assign is_err = (head.err != ERR_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (pop) valid_reg <= 1'b1;
        else if (tok_ready) valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= is_err ? K_MATCH : head.kind;
            tv_reg   <= !is_err && head.text_valid;
            tb_reg   <= (!is_err && head.text_valid) ? head.text_byte : 8'd0;
            done_reg <= !is_err && head.done;
            cnt_reg  <= is_err ? 32'd0 : 32'(head.count);
            err_reg  <= head.err;
            end_reg  <= head.last;
        end
    end

    assign tok_valid   = valid_reg;
    assign token_kind  = kind_reg;
    assign text_valid  = tv_reg;
    assign text_byte   = tb_reg;
    assign token_done  = done_reg;
    assign count_value = cnt_reg;
    assign error_code  = err_reg;
    assign pattern_end = end_reg;

endmodule
`default_nettype wire

/* rtl/route_pattern_tokenizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// route_pattern_tokenizer
// Streaming lexer for segment patterns, one byte per transaction.
// ----------------------------------------------------------------------------
// Takes one pattern byte per clock cycle and gives at most one result per
// byte: an unescaped text byte, a token close with kind and number, or a
// coded error, after which bytes are dropped through the last byte. A result
// is written into a two-entry queue when its byte is taken, and the output
// register loads it from there once empty or once its held result is taken.
// Input stalls only while that queue is full. Numbers saturate at all ones of
// min(COUNT_WIDTH, 32) bits.
module route_pattern_tokenizer #(
    parameter int COUNT_WIDTH = rpt_pkg::COUNT_WIDTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          pat_valid,
    output logic         pat_ready,
    input  wire  [7:0]   pattern_byte,
    input  wire          is_last,
    output logic         tok_valid,
    input  wire          tok_ready,
    output logic [3:0]   token_kind,
    output logic         text_valid,
    output logic [7:0]   text_byte,
    output logic         token_done,
    output logic [31:0]  count_value,
    output logic [2:0]   error_code,
    output logic         pattern_end
);
    import rpt_pkg::*;

    logic        fire;
    logic        push;
    logic        pop;
    logic        full;
    logic        not_empty;
    rpt_entry_t  entry;
    rpt_entry_t  head;

    assign pat_ready = !full;
    assign fire      = pat_valid && pat_ready;

    rpt_lexer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .pattern_byte (pattern_byte),
        .is_last      (is_last),
        .push         (push),
        .entry        (entry)
    );

    rpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    rpt_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (not_empty),
        .head        (head),
        .pop         (pop),
        .tok_valid   (tok_valid),
        .tok_ready   (tok_ready),
        .token_kind  (token_kind),
        .text_valid  (text_valid),
        .text_byte   (text_byte),
        .token_done  (token_done),
        .count_value (count_value),
        .error_code  (error_code),
        .pattern_end (pattern_end)
    );

endmodule
`default_nettype wire

/* rtl/rpt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_checker
// Port-level checks of the route pattern tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module rpt_checker (
    input wire         clk,
    input wire         rst_n,
    input wire         pat_ready,
    input wire         tok_valid,
    input wire         tok_ready,
    input wire  [3:0]  token_kind,
    input wire         text_valid,
    input wire  [7:0]  text_byte,
    input wire         token_done,
    input wire  [31:0] count_value,
    input wire  [2:0]  error_code,
    input wire         pattern_end
);
    import rpt_pkg::*;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(token_kind)
            && $stable(text_byte) && $stable(count_value) && $stable(error_code)
            && $stable(pattern_end))
        else $error("result changed while stalled");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && error_code != ERR_OK |-> token_kind == K_MATCH && !text_valid
            && !token_done && count_value == 32'd0 && text_byte == 8'd0)
        else $error("error result carries token fields");

    a_text_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> !(text_valid && token_done))
        else $error("text byte and token close in one result");

    a_text_only_count: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && text_valid |-> count_value == 32'd0)
        else $error("text result carries a count");

    a_input_pace: assert property (@(posedge clk) disable iff (!rst_n)
        !pat_ready |-> tok_valid)
        else $error("input stalled with output empty");

endmodule

bind route_pattern_tokenizer rpt_checker u_rpt_checker (.*);
`default_nettype wire

/* tb/tb_route_pattern_tokenizer.sv */
// ----------------------------------------------------------------------------
// tb_route_pattern_tokenizer
// Self-checking bench for the streaming segment-pattern lexer.
// ----------------------------------------------------------------------------
// A short list of directed patterns covers every token form, each escape,
// number saturation and each error code. Random patterns follow: mostly
// well-formed token sequences with random content, plus mutated, truncated
// and noise patterns. A local lexer predicts each result at input
// acceptance, and the monitor checks every output transaction in order.
// Both sides idle at random, the receiver holds off once for a long
// stretch, and the sender drains the block at several pattern boundaries.
// ----------------------------------------------------------------------------
module tb_route_pattern_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import rpt_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int STALL_LIMIT   = 3000;
    localparam int TAIL_CYCLES   = 10;
    localparam int CALM_START    = 700;
    localparam int CALM_END      = 1100;
    localparam int HOLD_AT       = 1400;
    localparam int HOLD_LEN      = 400;
    localparam int DRAIN_EVERY   = 40;
    localparam int MAX_REPORTS   = 10;

    localparam longint unsigned SAT_MAX = (COUNT_WIDTH_DEF < 32) ?
        ((64'd1 << COUNT_WIDTH_DEF) - 64'd1) : 64'h0000_0000_FFFF_FFFF;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] ESC_N     = 8'h6E;
    localparam logic [7:0] ESC_T     = 8'h74;
    localparam logic [7:0] ESC_R     = 8'h72;
    localparam logic [7:0] ESC_ZERO  = 8'h30;
    localparam logic [7:0] ESC_X     = 8'h78;

    typedef enum logic [4:0] {
        LX_IDLE, LX_DOLLAR, LX_BRACE, LX_BRACE_NUM, LX_BRACKET, LX_GT, LX_LT,
        LX_NUM_BRACKET, LX_E1, LX_E2, LX_E3, LX_END_MINUS, LX_QUOTE, LX_ESC,
        LX_HEX1, LX_HEX2, LX_AFTER_Q
    } lex_state_t;

    typedef struct {
        logic [7:0] b;
        bit         last;
        bit         drain;
    } pattern_item_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        pat_valid    = 1'b0;
    logic        pat_ready;
    logic [7:0]  pattern_byte = 8'h00;
    logic        is_last      = 1'b0;
    logic        tok_valid;
    logic        tok_ready    = 1'b0;
    logic [3:0]  token_kind;
    logic        text_valid;
    logic [7:0]  text_byte;
    logic        token_done;
    logic [31:0] count_value;
    logic [2:0]  error_code;
    logic        pattern_end;

    pattern_item_t pending_bytes[$];
    rpt_entry_t    expected_tokens[$];
    logic [7:0]    pat_buf[$];

    lex_state_t       lx_state;
    logic [3:0]       lx_kind;
    longint unsigned  lx_number;
    logic [3:0]       lx_high_nib;
    bit               lx_dropping;

    int cycle_count   = 0;
    int stall_cycles  = 0;
    int bytes_sent    = 0;
    int pattern_count = 0;
    int text_seen     = 0;
    int closes_seen   = 0;
    int errors_seen   = 0;
    int failures      = 0;

    wire calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

    route_pattern_tokenizer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pat_valid    (pat_valid),
        .pat_ready    (pat_ready),
        .pattern_byte (pattern_byte),
        .is_last      (is_last),
        .tok_valid    (tok_valid),
        .tok_ready    (tok_ready),
        .token_kind   (token_kind),
        .text_valid   (text_valid),
        .text_byte    (text_byte),
        .token_done   (token_done),
        .count_value  (count_value),
        .error_code   (error_code),
        .pattern_end  (pattern_end)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Lexer prediction
    // ------------------------------------------------------------------
    function automatic void clear_token();
        lx_state    = LX_IDLE;
        lx_kind     = K_MATCH;
        lx_number   = 0;
        lx_high_nib = 4'd0;
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic int nibble_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return c - 8'h30;
        if (c >= 8'h61 && c <= 8'h66)
            return c - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return c - 8'h41 + 10;
        return -1;
    endfunction

    function automatic void add_digit(logic [7:0] c);
        longint unsigned d;
        d = 64'(c - 8'h30);
        if (lx_number > SAT_MAX || lx_number > (SAT_MAX - d) / 10)
            lx_number = SAT_MAX;
        else
            lx_number = lx_number * 10 + d;
    endfunction

    function automatic void start_number(logic [3:0] kind, logic [7:0] c);
        lx_kind   = kind;
        lx_number = 0;
        add_digit(c);
    endfunction

    function automatic bit tokenize_byte(input logic [7:0] c, input bit last,
                                         output rpt_entry_t r);
        bit         have;
        bit         tv;
        bit         done;
        logic [7:0] tb;
        logic [2:0] err;
        logic [31:0] cnt;
        int         h;
        have = 1'b0;
        tv   = 1'b0;
        done = 1'b0;
        tb   = 8'h00;
        err  = ERR_OK;
        cnt  = 32'd0;
        r    = '0;
        if (lx_dropping)
        begin
            if (last)
            begin
                lx_dropping = 1'b0;
                clear_token();
            end
            return 1'b0;
        end
        case (lx_state)
            LX_IDLE:
                if (c == CH_DOLLAR) lx_state = LX_DOLLAR;
                else err = ERR_NO_DOLLAR;
            LX_DOLLAR:
                if (c == CH_QUOTE)
                begin
                    lx_kind  = K_MATCH;
                    lx_state = LX_QUOTE;
                end
                else if (c == CH_LBRACE) lx_state = LX_BRACE;
                else if (c == CH_LBRACK) lx_state = LX_BRACKET;
                else err = ERR_UNEXPECT;
            LX_BRACE:
                if (c == CH_RBRACE)
                begin
                    have     = 1'b1;
                    done     = 1'b1;
                    lx_kind  = K_CAP_END;
                    lx_state = LX_IDLE;
                end
                else if (c == CH_QUOTE)
                begin
                    lx_kind  = K_CAP_UNTIL;
                    lx_state = LX_QUOTE;
                end
                else if (digit_char(c))
                begin
                    start_number(K_CAP_BYTES, c);
                    lx_state = LX_BRACE_NUM;
                end
                else err = ERR_UNEXPECT;
            LX_BRACE_NUM:
                if (digit_char(c)) add_digit(c);
                else if (lx_number == 0) err = ERR_ZERO_CAP;
                else if (c == CH_RBRACE)
                begin
                    have     = 1'b1;
                    done     = 1'b1;
                    cnt      = 32'(lx_number);
                    lx_state = LX_IDLE;
                end
                else err = ERR_UNEXPECT;
            LX_BRACKET:
                if (c == CH_GT) lx_state = LX_GT;
                else if (c == CH_LT) lx_state = LX_LT;
                else if (c == CH_E) lx_state = LX_E1;
                else if (digit_char(c))
                begin
                    start_number(K_JUMP_ABS, c);
                    lx_state = LX_NUM_BRACKET;
                end
                else err = ERR_UNEXPECT;
            LX_GT, LX_LT:
                if (c == CH_QUOTE)
                begin
                    lx_kind  = (lx_state == LX_GT) ? K_FIND_FWD : K_FIND_REV;
                    lx_state = LX_QUOTE;
                end
                else if (digit_char(c))
                begin
                    start_number((lx_state == LX_GT) ? K_JUMP_FWD : K_JUMP_BACK, c);
                    lx_state = LX_NUM_BRACKET;
                end
                else err = ERR_UNEXPECT;
            LX_NUM_BRACKET:
                if (digit_char(c)) add_digit(c);
                else if (c == CH_RBRACK)
                begin
                    have     = 1'b1;
                    done     = 1'b1;
                    cnt      = 32'(lx_number);
                    lx_state = LX_IDLE;
                end
                else err = ERR_UNEXPECT;
            LX_E1:
                if (c == CH_N) lx_state = LX_E2;
                else err = ERR_UNEXPECT;
            LX_E2:
                if (c == CH_D) lx_state = LX_E3;
                else err = ERR_UNEXPECT;
            LX_E3:
            begin
                lx_kind = K_JUMP_END;
                if (c == CH_RBRACK)
                begin
                    have     = 1'b1;
                    done     = 1'b1;
                    lx_state = LX_IDLE;
                end
                else if (c == CH_MINUS) lx_state = LX_END_MINUS;
                else err = ERR_UNEXPECT;
            end
            LX_END_MINUS:
                if (digit_char(c))
                begin
                    start_number(K_JUMP_END, c);
                    lx_state = LX_NUM_BRACKET;
                end
                else err = ERR_UNEXPECT;
            LX_QUOTE:
                if (c == CH_QUOTE)
                begin
                    if (lx_kind == K_MATCH)
                    begin
                        have     = 1'b1;
                        done     = 1'b1;
                        lx_state = LX_IDLE;
                    end
                    else lx_state = LX_AFTER_Q;
                end
                else if (c == CH_BSLASH) lx_state = LX_ESC;
                else
                begin
                    have = 1'b1;
                    tv   = 1'b1;
                    tb   = c;
                end
            LX_ESC:
            begin
                lx_state = LX_QUOTE;
                have     = 1'b1;
                tv       = 1'b1;
                if (c == CH_BSLASH || c == CH_QUOTE) tb = c;
                else if (c == ESC_N) tb = 8'h0A;
                else if (c == ESC_T) tb = 8'h09;
                else if (c == ESC_R) tb = 8'h0D;
                else if (c == ESC_ZERO) tb = 8'h00;
                else
                begin
                    have = 1'b0;
                    tv   = 1'b0;
                    if (c == ESC_X) lx_state = LX_HEX1;
                    else err = ERR_ESCAPE;
                end
            end
            LX_HEX1:
            begin
                h = nibble_of(c);
                if (h < 0) err = ERR_HEX;
                else
                begin
                    lx_high_nib = 4'(h);
                    lx_state    = LX_HEX2;
                end
            end
            LX_HEX2:
            begin
                h = nibble_of(c);
                if (h < 0) err = ERR_HEX;
                else
                begin
                    have     = 1'b1;
                    tv       = 1'b1;
                    tb       = {lx_high_nib, 4'(h)};
                    lx_state = LX_QUOTE;
                end
            end
            LX_AFTER_Q:
                if (c == ((lx_kind == K_CAP_UNTIL) ? CH_RBRACE : CH_RBRACK))
                begin
                    have     = 1'b1;
                    done     = 1'b1;
                    lx_state = LX_IDLE;
                end
                else err = ERR_UNEXPECT;
            default:
                err = ERR_UNEXPECT;
        endcase
        if (err == ERR_OK && last && lx_state != LX_IDLE)
            err = ERR_MID_TOKEN;
        if (err != ERR_OK)
        begin
            r.err  = err;
            r.last = last;
            clear_token();
            lx_dropping = !last;
            return 1'b1;
        end
        if (!have)
            return 1'b0;
        r.kind       = lx_kind;
        r.text_valid = tv;
        r.text_byte  = tb;
        r.done       = done;
        r.count      = cnt;
        r.last       = last;
        if (done)
            clear_token();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Pattern generation
    // ------------------------------------------------------------------
    task automatic put(logic [7:0] b);
        pat_buf.push_back(b);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            pat_buf.push_back(s[i]);
    endtask

    task automatic emit_pattern(bit drain);
        pattern_item_t it;
        for (int i = 0; i < pat_buf.size(); i++)
        begin
            it.b     = pat_buf[i];
            it.last  = (i == pat_buf.size() - 1);
            it.drain = drain && (i == 0);
            pending_bytes.push_back(it);
        end
        pat_buf.delete();
        pattern_count++;
    endtask

    task automatic directed(string s);
        put_str(s);
        emit_pattern(1'b0);
    endtask

    function automatic logic [7:0] hex_char(int v);
        if (v < 10)
            return 8'(8'h30 + v);
        return 8'((($urandom_range(1) != 0) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    function automatic logic [7:0] syntax_byte();
        case ($urandom_range(15))
            0:  return CH_DOLLAR;
            1:  return CH_QUOTE;
            2:  return CH_LBRACE;
            3:  return CH_RBRACE;
            4:  return CH_LBRACK;
            5:  return CH_RBRACK;
            6:  return CH_GT;
            7:  return CH_LT;
            8:  return CH_E;
            9:  return CH_N;
            10: return CH_D;
            11: return CH_MINUS;
            12: return CH_BSLASH;
            13: return ESC_X;
            14: return 8'h30;
            default: return 8'h39;
        endcase
    endfunction

    task automatic put_text();
        int n;
        logic [7:0] b;
        n = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
        repeat (n)
        begin
            if ($urandom_range(99) < 65)
            begin
                b = 8'($urandom_range(255));
                if (b == CH_QUOTE || b == CH_BSLASH)
                    b = 8'h61;
                put(b);
            end
            else
            begin
                case ($urandom_range(6))
                    0: put_str("\\\\");
                    1: put_str("\\'");
                    2: put_str("\\n");
                    3: put_str("\\t");
                    4: put_str("\\r");
                    5: put_str("\\0");
                    default:
                    begin
                        put_str("\\x");
                        put(hex_char($urandom_range(15)));
                        put(hex_char($urandom_range(15)));
                    end
                endcase
            end
        end
    endtask

    task automatic put_number();
        int nd;
        int r;
        r  = $urandom_range(99);
        nd = (r < 70) ? $urandom_range(1, 3) :
             (r < 90) ? $urandom_range(4, 9) : $urandom_range(10, 13);
        for (int i = 0; i < nd; i++)
        begin
            if (i == 0 && $urandom_range(7) != 0)
                put(8'(8'h31 + $urandom_range(8)));
            else
                put(8'(8'h30 + $urandom_range(9)));
        end
    endtask

    task automatic put_token();
        case ($urandom_range(10))
            0:
            begin
                put_str("$'");
                put_text();
                put(CH_QUOTE);
            end
            1:
            begin
                put_str("${");
                put_number();
                put(CH_RBRACE);
            end
            2:
            begin
                put_str("${'");
                put_text();
                put_str("'}");
            end
            3: put_str("${}");
            4:
            begin
                put_str("$[");
                put_number();
                put(CH_RBRACK);
            end
            5: put_str("$[END]");
            6:
            begin
                put_str("$[END-");
                put_number();
                put(CH_RBRACK);
            end
            7:
            begin
                put_str("$[>");
                put_number();
                put(CH_RBRACK);
            end
            8:
            begin
                put_str("$[<");
                put_number();
                put(CH_RBRACK);
            end
            9:
            begin
                put_str("$[>'");
                put_text();
                put_str("']");
            end
            default:
            begin
                put_str("$[<'");
                put_text();
                put_str("']");
            end
        endcase
    endtask

    task automatic random_pattern(bit drain);
        int sel;
        int idx;
        int keep;
        sel = $urandom_range(99);
        if (sel < 94)
        begin
            repeat ($urandom_range(1, 4))
                put_token();
            if (sel >= 80 && sel < 88)
            begin
                idx = $urandom_range(pat_buf.size() - 1);
                pat_buf[idx] = ($urandom_range(1) != 0) ? syntax_byte() : 8'($urandom);
            end
            else if (sel >= 88)
            begin
                keep = $urandom_range(1, pat_buf.size() - 1);
                while (pat_buf.size() > keep)
                    void'(pat_buf.pop_back());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                put(($urandom_range(1) != 0) ? syntax_byte() : 8'($urandom));
        end
        emit_pattern(drain);
    endtask

    task automatic build_stimulus();
        int start_size;
        directed("${}");
        directed("${'a'}$[>'b']$[<'c']");
        directed("${12}$[7]$[END]$[END-3]$[>5]$[<4]");
        directed("$'\\\\\\'\\n\\t\\r\\0\\x4a\\xfF'");
        put_str("$'");
        put(8'h00);
        put(8'hFF);
        put(CH_QUOTE);
        emit_pattern(1'b0);
        directed("${4294967295}${4294967296}${99999999999}");
        directed("${0}");
        directed("a");
        directed("$?");
        directed("$'ab");
        directed("$'\\q'$[1]");
        directed("$'\\xG1'");
        start_size = pending_bytes.size();
        while (pending_bytes.size() - start_size < RANDOM_ITEMS)
            random_pattern((pattern_count % DRAIN_EVERY) == 0);
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver, monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rpt_entry_t    res;
        pattern_item_t cur;
        bit            offer;
        if (rst_n)
        begin
            if (pat_valid && pat_ready)
            begin
                bytes_sent++;
                if (tokenize_byte(pattern_byte, is_last, res))
                    expected_tokens.push_back(res);
            end
            if (!pat_valid || pat_ready)
            begin
                offer = 1'b0;
                if (pending_bytes.size() != 0 &&
                    !(pending_bytes[0].drain && expected_tokens.size() != 0) &&
                    (calm || $urandom_range(99) >= 15))
                    offer = 1'b1;
                if (offer)
                begin
                    cur = pending_bytes.pop_front();
                    pattern_byte <= cur.b;
                    is_last      <= cur.last;
                end
                pat_valid <= offer;
            end
        end
    end

    always @(posedge clk)
    begin
        int hold_left;
        if (rst_n)
        begin
            if (cycle_count == HOLD_AT)
                hold_left = HOLD_LEN;
            if (hold_left > 0)
            begin
                hold_left--;
                tok_ready <= 1'b0;
            end
            else
                tok_ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    task automatic report_failure(string what, rpt_entry_t want, rpt_entry_t got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%s: exp kind=%0d tv=%0d byte=%02h done=%0d cnt=%0d err=%0d end=%0d",
                     what, want.kind, want.text_valid, want.text_byte, want.done,
                     want.count, want.err, want.last, "\n      got kind=%0d tv=%0d ",
                     got.kind, got.text_valid, "byte=%02h done=%0d cnt=%0d err=%0d end=%0d",
                     got.text_byte, got.done, got.count, got.err, got.last);
    endtask

    always @(posedge clk)
    begin
        rpt_entry_t got;
        rpt_entry_t want;
        if (rst_n && tok_valid && tok_ready)
        begin
            got.kind       = token_kind;
            got.text_valid = text_valid;
            got.text_byte  = text_byte;
            got.done       = token_done;
            got.count      = count_value;
            got.err        = error_code;
            got.last       = pattern_end;
            if (expected_tokens.size() == 0)
                report_failure("unexpected result", '0, got);
            else
            begin
                want = expected_tokens.pop_front();
                if (want.err != ERR_OK) errors_seen++;
                else if (want.done) closes_seen++;
                else text_seen++;
                if (got.kind !== want.kind || got.text_valid !== want.text_valid ||
                    got.text_byte !== want.text_byte || got.done !== want.done ||
                    got.count !== want.count || got.err !== want.err ||
                    got.last !== want.last)
                    report_failure("field mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if ((pat_valid && pat_ready) || (tok_valid && tok_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("route_pattern_tokenizer: mismatch");
        $finish;
    end

    initial
    begin
        clear_token();
        lx_dropping = 1'b0;
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || pat_valid)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_tokens.size() != 0)
            failures++;
        $display("sent %0d bytes in %0d patterns, checked %0d text bytes, %0d closes, %0d errors",
                 bytes_sent, pattern_count, text_seen, closes_seen, errors_seen);
        $display("run included a %0d-cycle output hold-off and drained pauses", HOLD_LEN);
        if (failures == 0)
            $display("route_pattern_tokenizer: match");
        else
            $display("route_pattern_tokenizer: mismatch");
        $finish;
    end

endmodule

/* sim.f */
rtl/rpt_pkg.sv
rtl/rpt_lexer.sv
rtl/rpt_queue.sv
rtl/rpt_out.sv
rtl/route_pattern_tokenizer.sv
rtl/rpt_checker.sv
tb/tb_route_pattern_tokenizer.sv
